// ----- rtl/core/lca_pkg.sv -----
package lca_pkg;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CHECK,
        ST_SUM,
        ST_DRAIN,
        ST_VMUL,
        ST_VSCL,
        ST_VGRD,
        ST_WMUL,
        ST_WSUM,
        ST_CMUL,
        ST_CLAMP,
        ST_DONE
    } lca_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic push;
        logic acc_clr;
        logic rd_en;
        logic var_mul;
        logic var_scale;
        logic var_grade;
        logic wgt_mul;
        logic wgt_sum;
        logic cost_mul;
        logic cost_clamp;
        logic out_load;
    } lca_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic fast_path;
        logic few_samples;
        logic rd_last;
        logic pipe_busy;
        logic out_busy;
    } lca_sts_t;

    // weight registers
    typedef struct packed {
        logic [7:0] rtt_weight;
        logic [7:0] load_weight;
        logic [7:0] stability_weight;
    } lca_cfg_t;

    // register indexes
    localparam logic [1:0] REG_RTT_WEIGHT  = 2'd0;
    localparam logic [1:0] REG_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] REG_STAB_WEIGHT = 2'd2;

    localparam logic [7:0] RST_RTT_WEIGHT  = 8'd77;
    localparam logic [7:0] RST_LOAD_WEIGHT = 8'd102;
    localparam logic [7:0] RST_STAB_WEIGHT = 8'd77;

    // rtt grade steps
    localparam logic [15:0] RTT_STEP0 = 16'd10;
    localparam logic [15:0] RTT_STEP1 = 16'd50;
    localparam logic [15:0] RTT_STEP2 = 16'd100;
    localparam logic [15:0] RTT_STEP3 = 16'd200;
    localparam logic [9:0]  RG_LOW    = 10'd51;
    localparam logic [9:0]  RG_MID    = 10'd128;
    localparam logic [9:0]  RG_HIGH   = 10'd256;
    localparam logic [9:0]  RG_MAX    = 10'd512;

    // variation grade steps
    localparam logic [8:0] LG_LOW  = 9'd76;
    localparam logic [8:0] LG_MID  = 9'd179;
    localparam logic [8:0] LG_HIGH = 9'd384;

    // stability penalty
    localparam logic [19:0] IDLE_MIN_SEC = 20'd60;
    localparam logic [19:0] IDLE_CAP_SEC = 20'd1200;
    localparam logic [9:0]  IDLE_CAP    = 10'd512;
    localparam logic [32:0] DIV5_MUL    = 33'd52429;
    localparam int          DIV5_SHIFT  = 18;
    localparam logic [31:0] DIV75_MUL   = 32'd55925;
    localparam int          DIV75_SHIFT = 22;

    localparam logic [22:0] ONE_Q16  = 23'd65536;
    localparam logic [23:0] COST_MAX = 24'h7FFFFF;

endpackage

// ----- rtl/core/link_cost_adjuster.sv -----
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    neighbor, costs, rtt, timeouts, idle time
// m_        out        m_valid/m_ready    adjusted_cost
// apb       in         psel/penable       three 8-bit weights at 0x0, 0x4, 0x8
//
// one transaction at a time; a non-positive cost goes straight to the output register,
// a neighbor holding fewer than three samples skips the variation steps, otherwise the n
// stored samples of the neighbor (at most HISTORY_DEPTH) are read, one memory read per cycle
// a finished result waits in the output register while the next one is accepted
// reset clears fill counts and heads at once; the sample memory itself is not cleared
module link_cost_adjuster
    import lca_pkg::*;
#(
    parameter int NEIGHBOR_COUNT = 16,
    parameter int HISTORY_DEPTH  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_neighbor_index,
    input  logic signed [23:0] s_base_cost,
    input  logic signed [23:0] s_original_cost,
    input  logic               s_rtt_present,
    input  logic [15:0]        s_rtt_ms,
    input  logic               s_timeouts_present,
    input  logic [7:0]         s_timeout_total,
    input  logic               s_success_present,
    input  logic [19:0]        s_idle_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_adjusted_cost
);

    lca_cfg_t cfg_reg;
    lca_cmd_t cmd;
    lca_sts_t sts;

    assign pready = 1'b1;

    // weight registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rtt_weight       <= RST_RTT_WEIGHT;
            cfg_reg.load_weight      <= RST_LOAD_WEIGHT;
            cfg_reg.stability_weight <= RST_STAB_WEIGHT;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_RTT_WEIGHT:  cfg_reg.rtt_weight       <= pwdata[7:0];
                REG_LOAD_WEIGHT: cfg_reg.load_weight      <= pwdata[7:0];
                REG_STAB_WEIGHT: cfg_reg.stability_weight <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read
    always_comb begin
        case (paddr[3:2])
            REG_RTT_WEIGHT:  prdata = 32'(cfg_reg.rtt_weight);
            REG_LOAD_WEIGHT: prdata = 32'(cfg_reg.load_weight);
            REG_STAB_WEIGHT: prdata = 32'(cfg_reg.stability_weight);
            default:         prdata = '0;
        endcase
    end

    lca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lca_datapath #(
        .NEIGHBOR_COUNT (NEIGHBOR_COUNT),
        .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg                (cfg_reg),
        .s_neighbor_index   (s_neighbor_index),
        .s_base_cost        (s_base_cost),
        .s_original_cost    (s_original_cost),
        .s_rtt_present      (s_rtt_present),
        .s_rtt_ms           (s_rtt_ms),
        .s_timeouts_present (s_timeouts_present),
        .s_timeout_total    (s_timeout_total),
        .s_success_present  (s_success_present),
        .s_idle_seconds     (s_idle_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_adjusted_cost    (m_adjusted_cost)
    );

    // an accepted transaction blocks the input until it is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // a result loads only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !sts.out_busy)
        else $error("result overwrote a pending transaction");

    // a loaded result is presented next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

endmodule

// ----- rtl/core/lca_ctrl.sv -----
module lca_ctrl
    import lca_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lca_sts_t sts,
    output lca_cmd_t cmd
);

    lca_state_t state_reg;
    lca_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (sts.fast_path) begin
                    cmd.cost_clamp = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    cmd.push    = 1'b1;
                    cmd.acc_clr = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.few_samples ? ST_WMUL : ST_SUM;
            end
            ST_SUM: begin
                cmd.rd_en = 1'b1;
                if (sts.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_VMUL;
                end
            end
            ST_VMUL: begin
                cmd.var_mul = 1'b1;
                state_next  = ST_VSCL;
            end
            ST_VSCL: begin
                cmd.var_scale = 1'b1;
                state_next    = ST_VGRD;
            end
            ST_VGRD: begin
                cmd.var_grade = 1'b1;
                state_next    = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.wgt_mul = 1'b1;
                state_next  = ST_WSUM;
            end
            ST_WSUM: begin
                cmd.wgt_sum = 1'b1;
                state_next  = ST_CMUL;
            end
            ST_CMUL: begin
                cmd.cost_mul = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.cost_clamp = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/lca_datapath.sv -----
module lca_datapath
    import lca_pkg::*;
#(
    parameter int NEIGHBOR_COUNT = 16,
    parameter int HISTORY_DEPTH  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lca_cmd_t           cmd,
    output lca_sts_t           sts,
    input  lca_cfg_t           cfg,
    input  logic [3:0]         s_neighbor_index,
    input  logic signed [23:0] s_base_cost,
    input  logic signed [23:0] s_original_cost,
    input  logic               s_rtt_present,
    input  logic [15:0]        s_rtt_ms,
    input  logic               s_timeouts_present,
    input  logic [7:0]         s_timeout_total,
    input  logic               s_success_present,
    input  logic [19:0]        s_idle_seconds,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_adjusted_cost
);

    localparam int NBW = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;
    localparam int HW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int ABW = $clog2(NEIGHBOR_COUNT * HISTORY_DEPTH);
    localparam int SW  = 16 + CW;
    localparam int QW  = 32 + CW;
    localparam int DW  = 2 * SW;
    localparam int EW  = DW + 7;

    // captured transaction
    logic [3:0]         nb_reg;
    logic signed [23:0] base_reg;
    logic signed [23:0] orig_reg;
    logic               rtt_ok_reg;
    logic [15:0]        rtt_reg;
    logic               to_ok_reg;
    logic [7:0]         to_reg;
    logic               idle_ok_reg;
    logic [19:0]        idle_reg;

    // per neighbor ring state
    logic [CW-1:0]  fill_reg [NEIGHBOR_COUNT];
    logic [HW-1:0]  head_reg [NEIGHBOR_COUNT];
    logic [15:0]    ring_mem [NEIGHBOR_COUNT * HISTORY_DEPTH];

    logic [NBW-1:0] nb_idx;
    logic           nb_ok;
    logic [CW-1:0]  fill_cur;
    logic [HW-1:0]  head_cur;
    logic [ABW-1:0] row_addr;
    logic [ABW-1:0] wr_addr;
    logic [ABW-1:0] rd_addr;
    logic           wr_en;

    // read and accumulate pipeline
    logic [HW-1:0]  idx_reg;
    logic [15:0]    rdata_reg;
    logic           rvalid_reg;
    logic [15:0]    sval_reg;
    logic [31:0]    sq_reg;
    logic           sqv_reg;
    logic [SW-1:0]  s_reg;
    logic [QW-1:0]  q_reg;

    // grades and cost
    logic [DW-1:0]  s2_reg;
    logic [DW-1:0]  nq_reg;
    logic [EW-1:0]  d100_reg;
    logic [9:0]     rg_reg;
    logic [8:0]     lg_reg;
    logic [13:0]    sg_reg;
    logic [17:0]    p0_reg;
    logic [16:0]    p1_reg;
    logic [21:0]    p2_reg;
    logic [22:0]    mult_reg;
    logic [45:0]    prod_reg;
    logic [23:0]    res_reg;
    logic [23:0]    out_reg;
    logic           out_valid_reg;

    logic [9:0]     rg_next;
    logic [13:0]    sg_next;
    logic [32:0]    to_prod;
    logic [31:0]    idle_prod;
    logic [15:0]    idle_scaled;
    logic [9:0]     idle_grade;
    logic [8:0]     lg_next;
    logic [EW-1:0]  s2_ext;
    logic [45:0]    hi_lim;
    logic [45:0]    lo_lim;
    logic [45:0]    clamped;
    logic [29:0]    res_wide;
    logic [23:0]    res_next;

    // capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            nb_reg      <= s_neighbor_index;
            base_reg    <= s_base_cost;
            orig_reg    <= s_original_cost;
            rtt_ok_reg  <= s_rtt_present;
            rtt_reg     <= s_rtt_ms;
            to_ok_reg   <= s_timeouts_present;
            to_reg      <= s_timeout_total;
            idle_ok_reg <= s_success_present;
            idle_reg    <= s_idle_seconds;
        end
    end

    // ring addressing
    assign nb_idx   = NBW'(nb_reg);
    assign nb_ok    = 9'(nb_reg) < 9'(NEIGHBOR_COUNT);
    assign fill_cur = fill_reg[nb_idx];
    assign head_cur = head_reg[nb_idx];
    assign row_addr = ABW'(ABW'(nb_idx) * ABW'(HISTORY_DEPTH));
    assign wr_addr  = ABW'(row_addr + ABW'(head_cur));
    assign rd_addr  = ABW'(row_addr + ABW'(idx_reg));
    assign wr_en    = cmd.push && rtt_ok_reg && nb_ok;

    // head and fill per neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end else if (wr_en) begin
            head_reg[nb_idx] <= (head_cur == HW'(HISTORY_DEPTH - 1)) ? '0
                                                                     : head_cur + HW'(1);
            if (fill_cur < CW'(HISTORY_DEPTH)) begin
                fill_reg[nb_idx] <= fill_cur + CW'(1);
            end
        end
    end

    // sample memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= rtt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    // read index and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
            sqv_reg    <= 1'b0;
        end else begin
            rvalid_reg <= cmd.rd_en;
            sqv_reg    <= rvalid_reg;
            if (cmd.acc_clr) begin
                idx_reg <= '0;
            end else if (cmd.rd_en) begin
                idx_reg <= idx_reg + HW'(1);
            end
        end
    end

    // square and accumulate
    always_ff @(posedge aclk) begin
        sval_reg <= rdata_reg;
        sq_reg   <= 32'(rdata_reg) * 32'(rdata_reg);
        if (cmd.acc_clr) begin
            s_reg <= '0;
            q_reg <= '0;
        end else if (sqv_reg) begin
            s_reg <= s_reg + SW'(sval_reg);
            q_reg <= q_reg + QW'(sq_reg);
        end
    end

    // rtt grade
    always_comb begin
        if (!rtt_ok_reg || rtt_reg <= RTT_STEP0) begin
            rg_next = '0;
        end else if (rtt_reg <= RTT_STEP1) begin
            rg_next = RG_LOW;
        end else if (rtt_reg <= RTT_STEP2) begin
            rg_next = RG_MID;
        end else if (rtt_reg <= RTT_STEP3) begin
            rg_next = RG_HIGH;
        end else begin
            rg_next = RG_MAX;
        end
    end

    // stability penalty: timeouts*256/5 plus capped idle*256/600
    assign to_prod     = 33'({to_reg, 8'b0}) * DIV5_MUL;
    assign idle_scaled = {idle_reg[10:0], 5'b0};
    assign idle_prod   = 32'(idle_scaled) * DIV75_MUL;
    always_comb begin
        if (!idle_ok_reg || idle_reg <= IDLE_MIN_SEC) begin
            idle_grade = '0;
        end else if (idle_reg >= IDLE_CAP_SEC) begin
            idle_grade = IDLE_CAP;
        end else begin
            idle_grade = 10'(idle_prod >> DIV75_SHIFT);
        end
        sg_next = (to_ok_reg ? 14'(to_prod >> DIV5_SHIFT) : 14'd0) + 14'(idle_grade);
    end

    // variation grade from 100*(n*Q - S^2) against multiples of S^2
    assign s2_ext = EW'(s2_reg);
    always_comb begin
        if (s_reg == '0 || d100_reg <= s2_ext) begin
            lg_next = '0;
        end else if (d100_reg <= (s2_ext << 2)) begin
            lg_next = LG_LOW;
        end else if (d100_reg <= s2_ext * EW'(25)) begin
            lg_next = LG_MID;
        end else begin
            lg_next = LG_HIGH;
        end
    end

    // clamp to half and three times the original cost
    assign hi_lim   = (46'(orig_reg[22:0]) * 46'd3) << 16;
    assign lo_lim   = 46'(orig_reg[22:0]) << 15;
    always_comb begin
        clamped = (prod_reg > hi_lim) ? hi_lim : prod_reg;
        if (clamped < lo_lim) begin
            clamped = lo_lim;
        end
        res_wide = clamped[45:16];
        if (base_reg <= 0 || orig_reg <= 0) begin
            res_next = base_reg;
        end else if (res_wide > 30'(COST_MAX)) begin
            res_next = COST_MAX;
        end else begin
            res_next = res_wide[23:0];
        end
    end

    // grade and cost arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            rg_reg <= rg_next;
            sg_reg <= sg_next;
            lg_reg <= '0;
        end else if (cmd.var_grade) begin
            lg_reg <= lg_next;
        end
        if (cmd.var_mul) begin
            s2_reg <= DW'(s_reg) * DW'(s_reg);
            nq_reg <= DW'(fill_cur) * DW'(q_reg);
        end
        if (cmd.var_scale) begin
            d100_reg <= EW'(nq_reg - s2_reg) * EW'(100);
        end
        if (cmd.wgt_mul) begin
            p0_reg <= 18'(cfg.rtt_weight) * 18'(rg_reg);
            p1_reg <= 17'(cfg.load_weight) * 17'(lg_reg);
            p2_reg <= 22'(cfg.stability_weight) * 22'(sg_reg);
        end
        if (cmd.wgt_sum) begin
            mult_reg <= ONE_Q16 + 23'(p0_reg) + 23'(p1_reg) + 23'(p2_reg);
        end
        if (cmd.cost_mul) begin
            prod_reg <= 46'(base_reg[22:0]) * 46'(mult_reg);
        end
        if (cmd.cost_clamp) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_adjusted_cost = out_reg;

    // status
    assign sts.fast_path   = (base_reg <= 0) || (orig_reg <= 0);
    assign sts.few_samples = !nb_ok || (fill_cur < CW'(3));
    assign sts.rd_last     = CW'(idx_reg) == (fill_cur - CW'(1));
    assign sts.pipe_busy   = rvalid_reg || sqv_reg;
    assign sts.out_busy    = out_valid_reg && !m_ready;

endmodule

// ----- verif/link_cost_adjuster_tb.sv -----
`timescale 1ns / 1ps

module link_cost_adjuster_tb;
    import lca_pkg::*;

    // one link-cost request
    typedef struct {
        logic [3:0]         neighbor_index;
        logic signed [23:0] base_cost;
        logic signed [23:0] original_cost;
        logic               rtt_present;
        logic [15:0]        rtt_ms;
        logic               timeouts_present;
        logic [7:0]         timeout_total;
        logic               success_present;
        logic [19:0]        idle_seconds;
    } cost_req_t;

    localparam int RING_DEPTH  = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 40;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_neighbor_index = '0;
    logic signed [23:0] s_base_cost = '0;
    logic signed [23:0] s_original_cost = '0;
    logic               s_rtt_present = 1'b0;
    logic [15:0]        s_rtt_ms = '0;
    logic               s_timeouts_present = 1'b0;
    logic [7:0]         s_timeout_total = '0;
    logic               s_success_present = 1'b0;
    logic [19:0]        s_idle_seconds = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_adjusted_cost;

    // predictor state
    logic [15:0] rtt_hist [16][RING_DEPTH];
    int          hist_fill [16];
    int          hist_head [16];
    logic [7:0]  w_rtt = RST_RTT_WEIGHT;
    logic [7:0]  w_load = RST_LOAD_WEIGHT;
    logic [7:0]  w_stab = RST_STAB_WEIGHT;

    logic [23:0] expected_costs [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 0;
    int          hold_seq = 0;
    int          hold_len = 0;

    link_cost_adjuster uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // random gap: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // expected adjusted cost; updates the rtt history when both costs are positive and an rtt is present
    function automatic logic [23:0] predict_cost(input cost_req_t r);
        longint base, orig, adj, prod, hi, lo, res;
        longint unsigned s, q, s2, d, n, v;
        int rg, lg, sg, nb, p;
        base = longint'(r.base_cost);
        orig = longint'(r.original_cost);
        nb = r.neighbor_index;
        if (base <= 0 || orig <= 0) return r.base_cost;
        if (r.rtt_present) begin
            rtt_hist[nb][hist_head[nb]] = r.rtt_ms;
            hist_head[nb] = (hist_head[nb] + 1) % RING_DEPTH;
            if (hist_fill[nb] < RING_DEPTH) hist_fill[nb]++;
        end
        // stepped rtt grade
        if (!r.rtt_present || r.rtt_ms <= 10) rg = 0;
        else if (r.rtt_ms <= 50) rg = 51;
        else if (r.rtt_ms <= 100) rg = 128;
        else if (r.rtt_ms <= 200) rg = 256;
        else rg = 512;
        // variation grade from exact stddev/mean comparison
        lg = 0;
        n = hist_fill[nb];
        if (n >= 3) begin
            s = 0;
            q = 0;
            for (int i = 0; i < n; i++) begin
                v = rtt_hist[nb][i];
                s += v;
                q += v * v;
            end
            if (s != 0) begin
                s2 = s * s;
                d = n * q - s2;
                if (100 * d <= s2) lg = 0;
                else if (100 * d <= 4 * s2) lg = 76;
                else if (100 * d <= 25 * s2) lg = 179;
                else lg = 384;
            end
        end
        // timeout and idle penalty
        sg = 0;
        if (r.timeouts_present) sg += (int'(r.timeout_total) * 256) / 5;
        if (r.success_present && r.idle_seconds > 60) begin
            p = (int'(r.idle_seconds) * 256) / 600;
            sg += (p > 512) ? 512 : p;
        end
        adj = longint'(w_rtt) * rg + longint'(w_load) * lg + longint'(w_stab) * sg;
        prod = base * (65536 + adj);
        hi = orig * 3 * 65536;
        lo = orig * 32768;
        if (prod > hi) prod = hi;
        if (prod < lo) prod = lo;
        res = prod / 65536;
        if (res > 8388607) res = 8388607;
        return res[23:0];
    endfunction

    // send one request and record its expected cost on acceptance
    task automatic send_request(input cost_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_neighbor_index   <= r.neighbor_index;
        s_base_cost        <= r.base_cost;
        s_original_cost    <= r.original_cost;
        s_rtt_present      <= r.rtt_present;
        s_rtt_ms           <= r.rtt_ms;
        s_timeouts_present <= r.timeouts_present;
        s_timeout_total    <= r.timeout_total;
        s_success_present  <= r.success_present;
        s_idle_seconds     <= r.idle_seconds;
        do @(posedge aclk); while (!s_ready);
        expected_costs = {expected_costs, predict_cost(r)};
    endtask

    // wait until every result is back and the block is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_costs.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_weight(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom_range(0, 16777215)), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RTT_WEIGHT:  w_rtt = val;
            REG_LOAD_WEIGHT: w_load = val;
            REG_STAB_WEIGHT: w_stab = val;
            default: ;
        endcase
    endtask

    task automatic set_weights(input logic [7:0] wr, input logic [7:0] wl, input logic [7:0] ws);
        wait_idle();
        write_weight(REG_RTT_WEIGHT, wr);
        write_weight(REG_LOAD_WEIGHT, wl);
        write_weight(REG_STAB_WEIGHT, ws);
    endtask

    function automatic cost_req_t make_req(input int nb, input int base, input int orig,
                                           input int rp, input int ms, input int tp,
                                           input int tt, input int sp, input int idle);
        cost_req_t r;
        r.neighbor_index   = 4'(nb);
        r.base_cost        = 24'(base);
        r.original_cost    = 24'(orig);
        r.rtt_present      = 1'(rp);
        r.rtt_ms           = 16'(ms);
        r.timeouts_present = 1'(tp);
        r.timeout_total    = 8'(tt);
        r.success_present  = 1'(sp);
        r.idle_seconds     = 20'(idle);
        return r;
    endfunction

    // random request: mostly positive costs on a few neighbors so histories fill
    function automatic cost_req_t random_req();
        cost_req_t r;
        int k;
        r.neighbor_index = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                                       : 4'($urandom_range(0, 15));
        k = $urandom_range(0, 99);
        if (k < 75) r.base_cost = 24'($urandom_range(1, 200000));
        else if (k < 88) r.base_cost = 24'($urandom_range(1, 8388607));
        else if (k < 94) r.base_cost = 24'($urandom);
        else r.base_cost = 24'(-int'($urandom_range(0, 8388608)));
        k = $urandom_range(0, 99);
        if (k < 75) r.original_cost = 24'($urandom_range(1, 200000));
        else if (k < 90) r.original_cost = 24'($urandom_range(1, 8388607));
        else if (k < 96) r.original_cost = 24'($urandom);
        else r.original_cost = 24'(-int'($urandom_range(0, 8388608)));
        r.rtt_present = ($urandom_range(0, 9) != 0);
        k = $urandom_range(0, 99);
        if (k < 40) r.rtt_ms = 16'(100 + $urandom_range(0, 4));
        else if (k < 75) r.rtt_ms = 16'($urandom_range(0, 260));
        else if (k < 90) r.rtt_ms = 16'($urandom_range(0, 2000));
        else r.rtt_ms = 16'($urandom);
        r.timeouts_present = 1'($urandom_range(0, 1));
        r.timeout_total    = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 5))
                                                         : 8'($urandom);
        r.success_present  = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 50) r.idle_seconds = 20'($urandom_range(0, 1300));
        else r.idle_seconds = 20'($urandom);
        return r;
    endfunction

    task automatic test_directed();
        // non-positive costs pass through
        send_request(make_req(0, 0, 1000, 1, 50, 0, 0, 0, 0));
        send_request(make_req(0, -8388608, 1000, 1, 50, 0, 0, 0, 0));
        send_request(make_req(1, 5000, 0, 1, 50, 0, 0, 0, 0));
        send_request(make_req(1, 5000, -8388608, 1, 50, 0, 0, 0, 0));
        // rtt grade steps
        send_request(make_req(2, 4096, 4096, 1, 10, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 11, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 50, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 51, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 100, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 101, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 200, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 201, 0, 0, 0, 0));
        send_request(make_req(2, 4096, 4096, 1, 65535, 0, 0, 0, 0));
        // steady samples, then absent rtt
        send_request(make_req(3, 4096, 4096, 1, 100, 0, 0, 0, 0));
        send_request(make_req(3, 4096, 4096, 1, 100, 0, 0, 0, 0));
        send_request(make_req(3, 4096, 4096, 1, 100, 0, 0, 0, 0));
        send_request(make_req(3, 4096, 4096, 0, 65535, 0, 0, 0, 0));
        // zero-valued samples give a zero sum
        send_request(make_req(15, 4096, 4096, 1, 0, 0, 0, 0, 0));
        send_request(make_req(15, 4096, 4096, 1, 0, 0, 0, 0, 0));
        send_request(make_req(15, 4096, 4096, 1, 0, 0, 0, 0, 0));
        // timeout and idle penalty edges
        send_request(make_req(4, 4096, 4096, 0, 0, 1, 255, 1, 60));
        send_request(make_req(4, 4096, 4096, 0, 0, 1, 1, 1, 61));
        send_request(make_req(4, 4096, 4096, 0, 0, 0, 0, 1, 1048575));
        // clamp and saturation extremes
        send_request(make_req(5, 8388607, 8388607, 1, 65535, 1, 255, 1, 1048575));
        send_request(make_req(5, 1, 8388607, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_request(random_req());
    endtask

    task automatic test_weights();
        set_weights(8'd0, 8'd0, 8'd0);
        test_random(60);
        set_weights(8'd255, 8'd255, 8'd255);
        test_random(60);
        set_weights(8'($urandom), 8'($urandom), 8'($urandom));
        test_random(60);
        set_weights(RST_RTT_WEIGHT, RST_LOAD_WEIGHT, RST_STAB_WEIGHT);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_len = 400;
        hold_seq++;
        no_idle = 1;
        test_random(30);
        no_idle = 0;
    endtask

    // one request at a time, each waiting for its result
    task automatic test_one_by_one();
        repeat (20) begin
            send_request(random_req());
            s_valid <= 1'b0;
            while (expected_costs.size() != 0) @(posedge aclk);
        end
    endtask

    // receiver ready with random gaps and long hold-offs on request
    int rx_wait = 0;
    int hold_seen = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rx_wait = hold_len;
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_wait = pick_gap();
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_valid && m_ready) begin
                if (expected_costs.size() == 0) begin
                    $error("adjusted_cost unexpected transaction, actual %0d", m_adjusted_cost);
                    error_count++;
                end else if (m_adjusted_cost !== expected_costs[0]) begin
                    $error("adjusted_cost expected %0d actual %0d",
                           $signed(expected_costs[0]), m_adjusted_cost);
                    error_count++;
                    expected_costs.delete(0);
                end else begin
                    expected_costs.delete(0);
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            hist_fill[i] = 0;
            hist_head[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_weights();
        test_backpressure();
        test_one_by_one();
        test_random(495);
        wait_idle();
        if (error_count == 0 && expected_costs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lca_pkg.sv
rtl/core/lca_ctrl.sv
rtl/core/lca_datapath.sv
rtl/core/link_cost_adjuster.sv
verif/link_cost_adjuster_tb.sv
